FILE: rtl/core/grp_pkg.sv
// Package with constants and types shared by the guillotine rectangle packer.
package grp_pkg;

    localparam int MAX_FREE   = 64;
    localparam int COORD_BITS = 13;
    localparam int IDX_BITS   = $clog2(MAX_FREE);
    localparam int CNT_BITS   = $clog2(MAX_FREE + 1);

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t w;
        coord_t h;
    } rect_t;

    localparam logic [1:0] ST_PLACED  = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;
    localparam logic [1:0] ST_CLEARED = 2'd3;

    localparam logic [1:0] REG_BIN_W = 2'd0;
    localparam logic [1:0] REG_BIN_H = 2'd1;
    localparam logic [1:0] REG_FIT   = 2'd2;
    localparam logic [1:0] REG_SPLIT = 2'd3;

    // Fit rule codes; lower score wins, worst rules negate the score.
    localparam logic [2:0] FIT_BEST_AREA   = 3'd0;
    localparam logic [2:0] FIT_BEST_SHORT  = 3'd1;
    localparam logic [2:0] FIT_BEST_LONG   = 3'd2;
    localparam logic [2:0] FIT_WORST_AREA  = 3'd3;
    localparam logic [2:0] FIT_WORST_SHORT = 3'd4;
    localparam logic [2:0] FIT_WORST_LONG  = 3'd5;

    // Split rule codes that choose the cut direction.
    localparam logic [2:0] SPLIT_SHORTER_LEFT = 3'd0;
    localparam logic [2:0] SPLIT_LONGER_LEFT  = 3'd1;
    localparam logic [2:0] SPLIT_MIN_AREA     = 3'd2;
    localparam logic [2:0] SPLIT_MAX_AREA     = 3'd3;
    localparam logic [2:0] SPLIT_SHORTER_AXIS = 3'd4;
    localparam logic [2:0] SPLIT_LONGER_AXIS  = 3'd5;

endpackage

FILE: rtl/core/guillotine_rect_packer.sv
// Top level of the guillotine rectangle packer: free list memory, scan, compaction, split.
//
// The block keeps its free rectangles in a 64-entry synchronous memory with a
// registered read port and handles one transfer at a time. After reset it
// writes the whole bin into entry 0 (state S_INIT) before it takes input.
// A clear passes straight to the output register. An insert reads the valid
// entries in order through the read register and the scoring register,
// stopping early on an exact match, rereads the winner, shifts each later
// entry down by one place, then writes those of the two leftovers that are
// non-empty while the list has room. The memory port is the limit: each
// cycle performs at most one read and one write. The result is held in an
// output register until the consumer takes it; the next input is accepted
// once that register is free. Scores are compared as 28-bit signed values;
// the area products for scoring are 13 by 13 bits, and those of the
// area-based split rules get a registered stage of their own.
module guillotine_rect_packer
    import grp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         action,
    input  logic [12:0]  item_width,
    input  logic [12:0]  item_height,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [1:0]   status,
    output logic [12:0]  place_x,
    output logic [12:0]  place_y,
    output logic [12:0]  place_width,
    output logic [12:0]  place_height
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_PICK  = 4'd2;
    localparam logic [3:0] S_GET   = 4'd3;
    localparam logic [3:0] S_SPLIT = 4'd4;
    localparam logic [3:0] S_MOVE  = 4'd5;
    localparam logic [3:0] S_APP1  = 4'd6;
    localparam logic [3:0] S_APP2  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_INIT  = 4'd10;

    localparam int SW = 2 * COORD_BITS + 2;

    // Configuration registers.
    logic [12:0] bin_w_reg, bin_h_reg;
    logic [2:0]  fit_reg, split_reg;

    logic [3:0]          state_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] rd_idx_reg;
    logic                rd_vld_reg;
    logic [IDX_BITS-1:0] cur_idx_reg;
    coord_t              iw_reg, ih_reg;

    // Scan results.
    logic                found_reg, exact_reg;
    logic [IDX_BITS-1:0] best_reg;
    logic signed [SW-1:0] best_score_reg;
    coord_t              pw_reg, ph_reg;

    // Chosen rectangle and leftovers.
    rect_t               f_reg;
    rect_t               bot_reg, rgt_reg;
    logic [2*COORD_BITS-1:0] prod_a_reg, prod_b_reg;
    logic                ok_reg;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  status_reg;
    coord_t      px_reg, py_reg, pwo_reg, pho_reg;

    // Free list memory.
    rect_t               mem [MAX_FREE];
    rect_t               rdata_reg;
    logic                we;
    logic [IDX_BITS-1:0] waddr, raddr;
    rect_t               wdata;
    logic                re;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // APB port.
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[3:2])
            REG_BIN_W: prdata = {19'd0, bin_w_reg};
            REG_BIN_H: prdata = {19'd0, bin_h_reg};
            REG_FIT:   prdata = {29'd0, fit_reg};
            REG_SPLIT: prdata = {29'd0, split_reg};
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_w_reg <= 13'd1024;
            bin_h_reg <= 13'd1024;
            fit_reg   <= FIT_BEST_AREA;
            split_reg <= SPLIT_SHORTER_LEFT;
        end
        else if (cfg_wr && paddr[1:0] == 2'b00)
        begin
            case (paddr[3:2])
                REG_BIN_W: bin_w_reg <= pwdata[12:0];
                REG_BIN_H: bin_h_reg <= pwdata[12:0];
                REG_FIT:   fit_reg   <= pwdata[2:0];
                REG_SPLIT: split_reg <= pwdata[2:0];
                default:   ;
            endcase
        end
    end

    // Scoring of the entry that arrives from memory.
    rect_t r;
    logic  m_ex, m_rx, m_up, m_rot, m_fit;
    coord_t fw, fh;
    logic [2*COORD_BITS-1:0] f_area, i_area;
    logic signed [SW-1:0] area_d, lo_d, hi_d, score;
    coord_t dh, dv;

    assign r    = rdata_reg;
    assign m_ex = (iw_reg == r.w) && (ih_reg == r.h);
    assign m_rx = (ih_reg == r.w) && (iw_reg == r.h);
    assign m_up = (iw_reg <= r.w) && (ih_reg <= r.h);
    assign m_rot = (ih_reg <= r.w) && (iw_reg <= r.h);
    assign m_fit = m_up || m_rot;
    assign fw = m_up ? iw_reg : ih_reg;
    assign fh = m_up ? ih_reg : iw_reg;

    always_comb
    begin
        f_area = r.w * r.h;
        i_area = iw_reg * ih_reg;
        area_d = SW'(f_area) - SW'(i_area);
        dh = r.w - fw;
        dv = r.h - fh;
        lo_d = (dh < dv) ? SW'(dh) : SW'(dv);
        hi_d = (dh < dv) ? SW'(dv) : SW'(dh);
        case (fit_reg)
            FIT_BEST_AREA:   score = area_d;
            FIT_BEST_SHORT:  score = lo_d;
            FIT_BEST_LONG:   score = hi_d;
            FIT_WORST_AREA:  score = -area_d;
            FIT_WORST_SHORT: score = -lo_d;
            FIT_WORST_LONG:  score = -hi_d;
            default:         score = {1'b0, {(SW-1){1'b1}}};
        endcase
    end

    logic score_win;
    assign score_win = (fit_reg <= FIT_WORST_LONG) && (!found_reg || score < best_score_reg);

    // Split decision.
    coord_t lw, lh;
    logic   horiz;
    assign lw = f_reg.w - pw_reg;
    assign lh = f_reg.h - ph_reg;

    always_comb
    begin
        case (split_reg)
            SPLIT_SHORTER_LEFT: horiz = lw <= lh;
            SPLIT_LONGER_LEFT:  horiz = lw > lh;
            SPLIT_MIN_AREA:     horiz = prod_a_reg > prod_b_reg;
            SPLIT_MAX_AREA:     horiz = prod_a_reg <= prod_b_reg;
            SPLIT_SHORTER_AXIS: horiz = f_reg.w <= f_reg.h;
            SPLIT_LONGER_AXIS:  horiz = f_reg.w > f_reg.h;
            default:            horiz = 1'b1;
        endcase
    end

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;

    logic load_ok;
    assign load_ok = (bin_w_reg != 13'd0) && (bin_h_reg != 13'd0);

    logic bot_ne, rgt_ne;
    assign bot_ne = (bot_reg.w != '0) && (bot_reg.h != '0);
    assign rgt_ne = (rgt_reg.w != '0) && (rgt_reg.h != '0);

    // Memory port control.
    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = rdata_reg;
        re    = 1'b0;
        raddr = rd_idx_reg[IDX_BITS-1:0];
        case (state_reg)
            S_INIT:
            begin
                // Load the reset bin into entry 0.
                we    = 1'b1;
                waddr = '0;
                wdata = '{x: '0, y: '0, w: bin_w_reg, h: bin_h_reg};
            end
            S_IDLE:
            begin
                we    = in_acc && action && load_ok;
                waddr = '0;
                wdata = '{x: '0, y: '0, w: bin_w_reg, h: bin_h_reg};
                re    = 1'b0;
            end
            S_SCAN:
            begin
                re = rd_idx_reg < count_reg;
            end
            S_PICK:
            begin
                re    = 1'b1;
                raddr = best_reg;
            end
            S_MOVE:
            begin
                re    = rd_idx_reg < count_reg;
                we    = rd_vld_reg;
                waddr = cur_idx_reg;
                wdata = rdata_reg;
            end
            S_APP1:
            begin
                we    = bot_ne && (count_reg < CNT_BITS'(MAX_FREE));
                waddr = count_reg[IDX_BITS-1:0];
                wdata = bot_reg;
            end
            S_APP2:
            begin
                we    = rgt_ne && (count_reg < CNT_BITS'(MAX_FREE));
                waddr = count_reg[IDX_BITS-1:0];
                wdata = rgt_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= CNT_BITS'(1);
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            cur_idx_reg   <= '0;
            found_reg     <= 1'b0;
            exact_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_acc)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:
                begin
                    state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        iw_reg      <= item_width;
                        ih_reg      <= item_height;
                        rd_idx_reg  <= '0;
                        rd_vld_reg  <= 1'b0;
                        found_reg   <= 1'b0;
                        exact_reg   <= 1'b0;
                        px_reg      <= '0;
                        py_reg      <= '0;
                        pwo_reg     <= '0;
                        pho_reg     <= '0;
                        if (action)
                        begin
                            count_reg  <= load_ok ? CNT_BITS'(1) : '0;
                            status_reg <= ST_CLEARED;
                            state_reg  <= S_OUT;
                        end
                        else if (item_width == '0 || item_height == '0)
                        begin
                            status_reg <= ST_NOFIT;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    rd_vld_reg  <= re;
                    cur_idx_reg <= rd_idx_reg[IDX_BITS-1:0];
                    if (re)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (rd_vld_reg && !exact_reg)
                    begin
                        if (m_ex || m_rx)
                        begin
                            exact_reg <= 1'b1;
                            found_reg <= 1'b1;
                            best_reg  <= cur_idx_reg;
                            pw_reg    <= m_ex ? iw_reg : ih_reg;
                            ph_reg    <= m_ex ? ih_reg : iw_reg;
                        end
                        else if (m_fit && score_win)
                        begin
                            found_reg      <= 1'b1;
                            best_score_reg <= score;
                            best_reg       <= cur_idx_reg;
                            pw_reg         <= fw;
                            ph_reg         <= fh;
                        end
                    end
                    if ((!re && !rd_vld_reg) || exact_reg)
                    begin
                        if (found_reg)
                        begin
                            state_reg <= S_PICK;
                        end
                        else
                        begin
                            status_reg <= ST_NOFIT;
                            state_reg  <= S_OUT;
                        end
                    end
                end
                S_PICK:
                begin
                    state_reg <= S_GET;
                end
                S_GET:
                begin
                    f_reg      <= rdata_reg;
                    state_reg  <= S_MUL;
                end
                S_MUL:
                begin
                    prod_a_reg <= pw_reg * lh;
                    prod_b_reg <= lw * ph_reg;
                    state_reg  <= S_SPLIT;
                end
                S_SPLIT:
                begin
                    bot_reg.x <= f_reg.x;
                    bot_reg.y <= f_reg.y + ph_reg;
                    bot_reg.h <= lh;
                    bot_reg.w <= horiz ? f_reg.w : pw_reg;
                    rgt_reg.x <= f_reg.x + pw_reg;
                    rgt_reg.y <= f_reg.y;
                    rgt_reg.w <= lw;
                    rgt_reg.h <= horiz ? ph_reg : f_reg.h;
                    px_reg     <= f_reg.x;
                    py_reg     <= f_reg.y;
                    pwo_reg    <= pw_reg;
                    pho_reg    <= ph_reg;
                    ok_reg     <= 1'b1;
                    rd_idx_reg <= CNT_BITS'(best_reg) + 1'b1;
                    cur_idx_reg <= best_reg;
                    rd_vld_reg <= 1'b0;
                    state_reg  <= S_MOVE;
                end
                S_MOVE:
                begin
                    // Each entry read is written one place lower in the following cycle.
                    rd_vld_reg <= re;
                    if (re)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (rd_vld_reg)
                    begin
                        cur_idx_reg <= cur_idx_reg + 1'b1;
                    end
                    if (!re && !rd_vld_reg)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_APP1;
                    end
                end
                S_APP1:
                begin
                    if (we)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    else if (bot_ne)
                    begin
                        ok_reg <= 1'b0;
                    end
                    state_reg <= S_APP2;
                end
                S_APP2:
                begin
                    if (we)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                    status_reg <= (ok_reg && (we || !rgt_ne)) ? ST_PLACED : ST_DROPPED;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign place_x      = px_reg;
    assign place_y      = py_reg;
    assign place_width  = pwo_reg;
    assign place_height = pho_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_FREE))
        else $error("free count exceeds list depth");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (we && (state_reg == S_APP1 || state_reg == S_APP2))
            |-> (count_reg < CNT_BITS'(MAX_FREE)))
        else $error("append beyond list");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("result dropped while stalled");
`endif

endmodule
